>>> hw/rtl/jvt_pkg.sv
// ----------------------------------------------------------------------------
// jvt_pkg: shared types and constants of the joint velocity tracker
// Field widths, angle limits, register indexes, queue entry and helpers.
// ----------------------------------------------------------------------------
package jvt_pkg;

    // field widths
    localparam int JOINT_W    = 3;
    localparam int ANGLE_W    = 26;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 25;
    localparam int TICK_W     = 14;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 25;
    localparam int TDATA_W    = 56;
    localparam int TUSER_W    = 2;
    localparam int PROD_W     = 42;

    // default joint count
    localparam int JOINTS_DEF = 6;

    // front queue depth
    localparam int Q_DEPTH = 2;

    // angle limits in signed Q12.16 degrees (28 bits, 16 fraction bits), wide enough for every intermediate sum
    localparam logic signed [27:0] ANG_180     = 28'sd11796480;
    localparam logic signed [27:0] ANG_360     = 28'sd23592960;
    localparam logic signed [27:0] ANG_NEG_180 = -28'sd11796480;
    localparam logic signed [27:0] ANG_NEG_360 = -28'sd23592960;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VEL_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLEW      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TICK      = 2'd3;

    // configuration reset values
    localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd640;
    localparam logic [LIM_W-1:0]  VEL_LIMIT_RST = 25'd786432;
    localparam logic [LIM_W-1:0]  SLEW_RST      = 25'd157286;
    localparam logic [TICK_W-1:0] TICK_RST      = 14'd1311;

    // what the back end has to do with an item
    typedef enum logic [1:0] {
        KIND_TRACK,
        KIND_START,
        KIND_SKIP
    } kind_t;

    // one classified item in the queue
    typedef struct packed {
        kind_t                      kind;
        logic [JOINT_W-1:0]         joint;
        logic signed [ANGLE_W-1:0]  ref_angle;
        logic signed [ANGLE_W-1:0]  meas_angle;
        logic                       meas_valid;
    } entry_t;

    // saturate an angle to +-360 degrees
    function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [27:0] a);
        logic signed [27:0] r;
        begin
            if (a > ANG_360)
            begin
                r = ANG_360;
            end
            else if (a < ANG_NEG_360)
            begin
                r = ANG_NEG_360;
            end
            else
            begin
                r = a;
            end
            return r[ANGLE_W-1:0];
        end
    endfunction

endpackage

>>> hw/rtl/jvt_front.sv
// ----------------------------------------------------------------------------
// jvt_front: input side of the joint velocity tracker
// Accepts stream transactions, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module jvt_front
    import jvt_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic [TUSER_W-1:0] s_tuser,
    output logic               q_valid,
    output entry_t             q_entry,
    input  logic               q_pop
);

    localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W = $clog2(Q_DEPTH + 1);

    entry_t              q_reg [Q_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    entry_t              in_entry;
    logic                push;
    logic                in_range;

    // field decode and classification
    always_comb
    begin
        in_range            = (32'(s_tdata[JOINT_W-1:0]) < 32'(JOINTS));
        in_entry.joint      = s_tdata[JOINT_W-1:0];
        in_entry.ref_angle  = s_tdata[JOINT_W+ANGLE_W-1:JOINT_W];
        in_entry.meas_angle = s_tdata[JOINT_W+2*ANGLE_W-1:JOINT_W+ANGLE_W];
        in_entry.meas_valid = s_tuser[1];
        if (!in_range)
        begin
            in_entry.kind = KIND_SKIP;
        end
        else if (s_tuser[0])
        begin
            in_entry.kind = KIND_START;
        end
        else
        begin
            in_entry.kind = KIND_TRACK;
        end
    end

    assign s_tready = (count_reg != QCNT_W'(Q_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = q_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_entry;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, q_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> hw/rtl/jvt_back.sv
// ----------------------------------------------------------------------------
// jvt_back: execution side of the joint velocity tracker
// Sequencer with one shared multiplier, per-joint state and the result register.
// ----------------------------------------------------------------------------
module jvt_back
    import jvt_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  q_valid,
    input  entry_t                q_entry,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata
);

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int IW = (JW > JOINT_W) ? JW : JOINT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_CLAMP,
        ST_SLEW,
        ST_INTEG,
        ST_EST,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic [LIM_W-1:0]           lim_reg;
    logic [LIM_W-1:0]           slew_reg;
    logic [TICK_W-1:0]          tick_reg;

    logic signed [ANGLE_W-1:0]  est_arr_reg  [JOINTS];
    logic signed [ANGLE_W-1:0]  last_arr_reg [JOINTS];

    logic [JW-1:0]              idx_reg;
    logic [JOINT_W-1:0]         joint_reg;
    logic signed [ANGLE_W-1:0]  est_reg;
    logic signed [ANGLE_W-1:0]  last_reg;
    logic signed [27:0]         err_reg;
    logic signed [ANGLE_W-1:0]  v_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       neg_reg;
    logic signed [ANGLE_W-1:0]  res_vel_reg;
    logic signed [ANGLE_W-1:0]  res_est_reg;

    logic                       m_tvalid_reg;
    logic [JOINT_W-1:0]         m_joint_reg;
    logic signed [ANGLE_W-1:0]  m_vel_reg;
    logic signed [ANGLE_W-1:0]  m_est_reg;

    logic [IW-1:0]              jext;
    logic [JW-1:0]              idx_in;
    logic signed [ANGLE_W-1:0]  est_cur;
    logic signed [ANGLE_W-1:0]  last_cur;
    logic signed [ANGLE_W-1:0]  est_sel;
    logic signed [27:0]         err_in;
    logic signed [ANGLE_W-1:0]  meas_sat;
    logic signed [27:0]         err_neg;
    logic [ANGLE_W-1:0]         err_mag;
    logic signed [27:0]         v_neg;
    logic [ANGLE_W-1:0]         v_mag;
    logic [ANGLE_W-1:0]         mul_a;
    logic [GAIN_W-1:0]          mul_b;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-1:0]          rnd8;
    logic [PROD_W-9:0]          p8;
    logic [LIM_W-1:0]           pm;
    logic signed [ANGLE_W-1:0]  v_clamp;
    logic signed [27:0]         v_wide;
    logic signed [27:0]         hi;
    logic signed [27:0]         lo;
    logic signed [ANGLE_W-1:0]  v_slew;
    logic [PROD_W-1:0]          rnd16;
    logic [ANGLE_W-1:0]         s16;
    logic signed [27:0]         step;
    logic signed [27:0]         est_sum;
    logic signed [ANGLE_W-1:0]  est_new;
    logic                       out_free;

    // state lookup for the item at the head of the queue
    assign jext     = IW'(q_entry.joint);
    assign idx_in   = jext[JW-1:0];
    assign est_cur  = est_arr_reg[idx_in];
    assign last_cur = last_arr_reg[idx_in];
    assign est_sel  = q_entry.meas_valid ? q_entry.meas_angle : est_cur;
    assign err_in   = 28'(q_entry.ref_angle) - 28'(est_sel);
    assign meas_sat = sat_angle(28'(q_entry.meas_angle));
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    // shared multiplier: wrapped error times gain, then velocity times tick
    assign err_neg = -err_reg;
    assign err_mag = err_reg[27] ? err_neg[ANGLE_W-1:0] : err_reg[ANGLE_W-1:0];
    assign v_neg   = -28'(v_reg);
    assign v_mag   = v_reg[ANGLE_W-1] ? v_neg[ANGLE_W-1:0] : v_reg;
    assign mul_a   = (state_reg == ST_WRAP) ? err_mag : v_mag;
    assign mul_b   = (state_reg == ST_WRAP) ? gain_reg : GAIN_W'(tick_reg);
    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);

    // rounding of the gain product and speed clamp on the magnitude
    assign rnd8    = prod_reg + PROD_W'(128);
    assign p8      = rnd8[PROD_W-1:8];
    assign pm      = (p8 > (PROD_W-8)'(lim_reg)) ? lim_reg : p8[LIM_W-1:0];
    assign v_clamp = neg_reg ? -ANGLE_W'(pm) : ANGLE_W'(pm);

    // slew limit against the last command
    assign v_wide = 28'(v_reg);
    assign hi     = 28'(last_reg) + 28'(slew_reg);
    assign lo     = 28'(last_reg) - 28'(slew_reg);
    assign v_slew = (v_wide > hi) ? hi[ANGLE_W-1:0] :
                    (v_wide < lo) ? lo[ANGLE_W-1:0] : v_reg;

    // integration step with rounding and saturation
    assign rnd16   = prod_reg + PROD_W'(32768);
    assign s16     = rnd16[16+ANGLE_W-1:16];
    assign step    = neg_reg ? -28'(s16) : 28'(s16);
    assign est_sum = 28'(est_reg) + step;
    assign est_new = sat_angle(est_sum);

    assign out_free = !m_tvalid_reg || m_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RST;
            lim_reg  <= VEL_LIMIT_RST;
            slew_reg <= SLEW_RST;
            tick_reg <= TICK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_GAIN:      gain_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_VEL_LIMIT: lim_reg  <= cfg_wdata[LIM_W-1:0];
                CFG_SLEW:      slew_reg <= cfg_wdata[LIM_W-1:0];
                CFG_TICK:      tick_reg <= cfg_wdata[TICK_W-1:0];
                default:       gain_reg <= gain_reg;
            endcase
        end
    end

    // sequencer, joint state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            for (int i = 0; i < JOINTS; i++)
            begin
                est_arr_reg[i]  <= '0;
                last_arr_reg[i] <= '0;
            end
            idx_reg      <= '0;
            joint_reg    <= '0;
            est_reg      <= '0;
            last_reg     <= '0;
            err_reg      <= '0;
            v_reg        <= '0;
            prod_reg     <= '0;
            neg_reg      <= 1'b0;
            res_vel_reg  <= '0;
            res_est_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_joint_reg  <= '0;
            m_vel_reg    <= '0;
            m_est_reg    <= '0;
        end
        else
        begin
            // output taken while no new result is being loaded
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        idx_reg   <= idx_in;
                        joint_reg <= q_entry.joint;
                        case (q_entry.kind)
                            KIND_TRACK:
                            begin
                                est_reg   <= est_sel;
                                last_reg  <= last_cur;
                                err_reg   <= err_in;
                                state_reg <= ST_WRAP;
                            end
                            KIND_START:
                            begin
                                est_arr_reg[idx_in]  <= meas_sat;
                                last_arr_reg[idx_in] <= '0;
                                res_vel_reg          <= '0;
                                res_est_reg          <= meas_sat;
                                state_reg            <= ST_DONE;
                            end
                            default:
                            begin
                                res_vel_reg <= '0;
                                res_est_reg <= '0;
                                state_reg   <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_WRAP:
                begin
                    // one turn per cycle until the error is in (-180,180]
                    if (err_reg > ANG_180)
                    begin
                        err_reg <= err_reg - ANG_360;
                    end
                    else if (err_reg <= ANG_NEG_180)
                    begin
                        err_reg <= err_reg + ANG_360;
                    end
                    else
                    begin
                        prod_reg  <= prod;
                        neg_reg   <= err_reg[27];
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP:
                begin
                    v_reg     <= v_clamp;
                    state_reg <= ST_SLEW;
                end
                ST_SLEW:
                begin
                    v_reg                 <= v_slew;
                    last_arr_reg[idx_reg] <= v_slew;
                    res_vel_reg           <= v_slew;
                    state_reg             <= ST_INTEG;
                end
                ST_INTEG:
                begin
                    prod_reg  <= prod;
                    neg_reg   <= v_reg[ANGLE_W-1];
                    state_reg <= ST_EST;
                end
                ST_EST:
                begin
                    est_arr_reg[idx_reg] <= est_new;
                    res_est_reg          <= est_new;
                    state_reg            <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_joint_reg  <= joint_reg;
                        m_vel_reg    <= res_vel_reg;
                        m_est_reg    <= res_est_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({m_est_reg, m_vel_reg, m_joint_reg});

endmodule

>>> hw/rtl/joint_velocity_tracker_unit.sv
// ----------------------------------------------------------------------------
// joint_velocity_tracker_unit: per-joint velocity tracker, top level
// Proportional velocity command with speed clamp, slew limit and estimate integration per joint.
// ----------------------------------------------------------------------------
// Each input transaction names one joint and yields one output transaction.
// A track item passes through error wrap (one 360 degree turn at a time),
// speed clamp, slew limit, integration and estimate update; a start item
// or an item for a joint beyond the joint count goes straight to the
// result. The sequencer runs the gain and integration products one after
// the other through a single 26x16 multiplier. A two-entry queue in front
// keeps accepting while the back end works, until it is full, and the
// output register holds a finished result while the next one is computed.
// Configuration writes land at once and are meant for idle periods only.
module joint_velocity_tracker_unit
    import jvt_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // joint[2:0], ref_angle[28:3], meas_angle[54:29]
    input  logic [TUSER_W-1:0]    s_tuser,   // op[0], meas_valid[1]
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // joint_out[2:0], vel_cmd[28:3], est_angle_out[54:29]
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic   q_valid;
    entry_t q_entry;
    logic   q_pop;

    // accept and classify
    jvt_front #(
        .JOINTS (JOINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    // execute and deliver
    jvt_back #(
        .JOINTS (JOINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
